// ===== sv/tbik_pkg.sv =====
package tbik_pkg;

   localparam int DIFF_W = 33;
   localparam int LEN_W = 40;
   localparam int DIST_W = 33;
   localparam int NORM_W = 30;
   localparam int PROD_W = 60;
   localparam int SUM_W = 63;
   localparam int DEN_W = 61;
   localparam int QUO_W = 31;
   localparam int ANG_W = 16;
   localparam int CRD_W = 36;
   localparam int CSR_IDX_W = 3;
   localparam int SQA_IN_W = 66;
   localparam int SQB_IN_W = 62;
   localparam int SQA_N = SQA_IN_W / 2;
   localparam int SQB_N = SQB_IN_W / 2;
   localparam int DIV_STEPS = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DISTANCE,
      CSR_MAX_DISTANCE,
      CSR_FLIP_BEND,
      CSR_REST_ANGLE_ONE,
      CSR_REST_ANGLE_TWO
   } csr_index_type;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
      logic [LEN_W-1:0]  l1;
      logic [LEN_W-1:0]  l2;
      logic [LEN_W-1:0]  mx;
      logic [DIST_W-1:0] dlen;
      logic [NORM_W-1:0] sd;
      logic [NORM_W-1:0] s1;
      logic [NORM_W-1:0] s2;
      logic              oor;
      logic              bad;
      logic              neg0;
      logic              neg1;
      logic              eq0;
      logic              eq1;
      logic [QUO_W-1:0]  q0;
      logic [QUO_W-1:0]  q1;
   } ctx_type;

   typedef struct packed {
      logic [DEN_W-1:0]     r;
      logic [DEN_W-1:0]     den;
      logic [DIV_STEPS-1:0] q;
   } div_type;

endpackage

// ===== sv/two_bone_ik_solver_core.sv =====
// Planar two-bone solver: one target beat may be taken in every cycle and each result beat
// appears CORDIC_STEPS + 109 cycles after its request beat when the result side never stalls.
// The latency is set by the pipelined square roots (33 and 31 stages), the 30-stage cosine
// divider and the three unrolled CORDIC units of CORDIC_STEPS + 2 stages. A stall on the
// result side holds the whole pipeline, and the configuration registers are read as items pass.
module two_bone_ik_solver_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_joint_x,
   input  logic signed [31:0] req_joint_y,
   input  logic [31:0]        req_length_one,
   input  logic [15:0]        req_scale_one_x,
   input  logic [15:0]        req_scale_one_y,
   input  logic [31:0]        req_length_two,
   input  logic [15:0]        req_scale_two_x,
   input  logic [15:0]        req_scale_two_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_update_valid,
   output logic               rsp_out_of_reach,
   output logic signed [15:0] rsp_rotation_one,
   output logic signed [15:0] rsp_rotation_two,
   output logic               rsp_rotation_two_global,
   input  logic               csr_we,
   input  logic [tbik_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int LC = CORDIC_STEPS + 2;
   localparam int VLAT = 12 + tbik_pkg::SQA_N + tbik_pkg::DIV_STEPS + tbik_pkg::SQB_N + LC;
   localparam int NW = tbik_pkg::NORM_W;
   localparam int PW = tbik_pkg::PROD_W;
   localparam int SW = tbik_pkg::SUM_W;
   localparam int DW = tbik_pkg::DEN_W;
   localparam int AW = tbik_pkg::ANG_W;

   logic en;

   logic [31:0] min_dist_ff;
   logic [31:0] max_dist_ff;
   logic        flip_ff;
   logic [15:0] rest_one_ff;
   logic [15:0] rest_two_ff;

   logic [VLAT-1:0] vld_ff;
   logic            rsp_valid_ff;
   logic            upd_ff;
   logic            oor_ff;
   logic [AW-1:0]   rot1_ff;
   logic [AW-1:0]   rot2_ff;
   logic            glob_ff;

   tbik_pkg::ctx_type ctx1_in, ctx1_ff, ctx2_ff, ctx3_ff;
   tbik_pkg::ctx_type ctxa_ff [tbik_pkg::SQA_N];
   tbik_pkg::ctx_type ctx4_in, ctx4_ff, ctx5_in, ctx5_ff, ctx6_in, ctx6_ff;
   tbik_pkg::ctx_type ctx7_ff, ctx8_ff, ctx9_in, ctx9_ff;
   tbik_pkg::ctx_type ctxd_ff [tbik_pkg::DIV_STEPS];
   tbik_pkg::ctx_type ctx10_in, ctx10_ff, ctx11_ff, ctx12_ff;
   tbik_pkg::ctx_type ctxs_ff [tbik_pkg::SQB_N];
   tbik_pkg::ctx_type ctxc_ff [LC];
   tbik_pkg::ctx_type ctxf;

   logic [tbik_pkg::DIFF_W-1:0] ax_in, ay_in, ax_ff, ay_ff;
   logic [47:0] lp1, lp2;
   logic [15:0] ms1, ms2;
   logic [tbik_pkg::SQA_IN_W-1:0] sqx_ff, sqy_ff, sum_ff;
   logic [tbik_pkg::SQA_N-1:0]    dist_root;
   logic [3:0] sh;
   logic [PW-1:0] psd_ff, ps1_ff, ps2_ff, pd1_ff, p21_ff;
   logic signed [SW-1:0] num0_ff, num1_ff;
   logic [DW-1:0] den0_ff, den1_ff;
   logic [SW-1:0] a0, a1;
   tbik_pkg::div_type dv0_in [2];
   tbik_pkg::div_type dv0_ff [2];
   tbik_pkg::div_type dv_ff [tbik_pkg::DIV_STEPS][2];
   logic [2*tbik_pkg::QUO_W-1:0] qq_ff [2];
   logic [tbik_pkg::SQB_IN_W-1:0] rad_ff [2];
   logic [tbik_pkg::SQB_N-1:0] sin_root [2];
   logic signed [tbik_pkg::CRD_W-1:0] cx [3];
   logic signed [tbik_pkg::CRD_W-1:0] cy [3];
   logic [AW-1:0] ang [3];
   logic [AW-1:0] a0f, a1f;
   logic upd_in, oor_in, glob_in;
   logic [AW-1:0] rot1_in, rot2_in;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= '0;
         max_dist_ff <= '0;
         flip_ff <= 1'b0;
         rest_one_ff <= '0;
         rest_two_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tbik_pkg::CSR_MIN_DISTANCE:   min_dist_ff <= csr_wdata;
            tbik_pkg::CSR_MAX_DISTANCE:   max_dist_ff <= csr_wdata;
            tbik_pkg::CSR_FLIP_BEND:      flip_ff <= csr_wdata[0];
            tbik_pkg::CSR_REST_ANGLE_ONE: rest_one_ff <= csr_wdata[15:0];
            tbik_pkg::CSR_REST_ANGLE_TWO: rest_two_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[VLAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VLAT-1];
      end
   end

   always_comb begin
      ctx1_in = '0;
      ctx1_in.dx = {req_target_x[31], req_target_x} - {req_joint_x[31], req_joint_x};
      ctx1_in.dy = {req_target_y[31], req_target_y} - {req_joint_y[31], req_joint_y};
      ax_in = ctx1_in.dx[32] ? -ctx1_in.dx : ctx1_in.dx;
      ay_in = ctx1_in.dy[32] ? -ctx1_in.dy : ctx1_in.dy;
      ms1 = (req_scale_one_x < req_scale_one_y) ? req_scale_one_x : req_scale_one_y;
      ms2 = (req_scale_two_x < req_scale_two_y) ? req_scale_two_x : req_scale_two_y;
      lp1 = req_length_one * ms1;
      lp2 = req_length_two * ms2;
      ctx1_in.l1 = lp1[47:8];
      ctx1_in.l2 = lp2[47:8];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx1_ff <= ctx1_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         ctx2_ff <= ctx1_ff;
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
         ctx3_ff <= ctx2_ff;
         sum_ff <= sqx_ff + sqy_ff;
         ctxa_ff[0] <= ctx3_ff;
         for (int k = 1; k < tbik_pkg::SQA_N; k++) ctxa_ff[k] <= ctxa_ff[k-1];
      end
   end

   tbik_sqrt #(.IN_W(tbik_pkg::SQA_IN_W)) u_dist_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum_ff),
      .root     (dist_root)
   );

   always_comb begin
      ctx4_in = ctxa_ff[tbik_pkg::SQA_N-1];
      ctx4_in.dlen = dist_root;
      if (dist_root < {1'b0, min_dist_ff}) ctx4_in.dlen = {1'b0, min_dist_ff};
      if ((max_dist_ff != '0) && (ctx4_in.dlen > {1'b0, max_dist_ff})) begin
         ctx4_in.dlen = {1'b0, max_dist_ff};
      end

      ctx5_in = ctx4_ff;
      ctx5_in.oor = ({1'b0, ctx4_ff.l1} + {1'b0, ctx4_ff.l2}) < {8'b0, ctx4_ff.dlen};
      ctx5_in.mx = {7'b0, ctx4_ff.dlen};
      if (ctx4_ff.l1 > ctx5_in.mx) ctx5_in.mx = ctx4_ff.l1;
      if (ctx4_ff.l2 > ctx5_in.mx) ctx5_in.mx = ctx4_ff.l2;

      ctx6_in = ctx5_ff;
      sh = '0;
      for (int b = NW; b < tbik_pkg::LEN_W; b++) begin
         if (ctx5_ff.mx[b]) sh = 4'(b - NW + 1);
      end
      ctx6_in.sd = NW'(ctx5_ff.dlen >> sh);
      ctx6_in.s1 = NW'(ctx5_ff.l1 >> sh);
      ctx6_in.s2 = NW'(ctx5_ff.l2 >> sh);
      ctx6_in.bad = (ctx6_in.sd == '0) || (ctx6_in.s1 == '0) || (ctx6_in.s2 == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx4_ff <= ctx4_in;
         ctx5_ff <= ctx5_in;
         ctx6_ff <= ctx6_in;
         ctx7_ff <= ctx6_ff;
         psd_ff <= ctx6_ff.sd * ctx6_ff.sd;
         ps1_ff <= ctx6_ff.s1 * ctx6_ff.s1;
         ps2_ff <= ctx6_ff.s2 * ctx6_ff.s2;
         pd1_ff <= ctx6_ff.sd * ctx6_ff.s1;
         p21_ff <= ctx6_ff.s2 * ctx6_ff.s1;
         ctx8_ff <= ctx7_ff;
         num0_ff <= $signed({3'b0, psd_ff}) + $signed({3'b0, ps1_ff}) - $signed({3'b0, ps2_ff});
         num1_ff <= $signed({3'b0, ps2_ff}) + $signed({3'b0, ps1_ff}) - $signed({3'b0, psd_ff});
         den0_ff <= {pd1_ff, 1'b0};
         den1_ff <= {p21_ff, 1'b0};
      end
   end

   always_comb begin
      ctx9_in = ctx8_ff;
      a0 = num0_ff[SW-1] ? SW'(-num0_ff) : SW'(num0_ff);
      a1 = num1_ff[SW-1] ? SW'(-num1_ff) : SW'(num1_ff);
      ctx9_in.neg0 = num0_ff[SW-1];
      ctx9_in.neg1 = num1_ff[SW-1];
      ctx9_in.eq0 = a0 == {2'b0, den0_ff};
      ctx9_in.eq1 = a1 == {2'b0, den1_ff};
      ctx9_in.bad = ctx8_ff.bad || (a0 > {2'b0, den0_ff}) || (a1 > {2'b0, den1_ff});
      dv0_in[0].r = a0[DW-1:0];
      dv0_in[0].den = den0_ff;
      dv0_in[0].q = '0;
      dv0_in[1].r = a1[DW-1:0];
      dv0_in[1].den = den1_ff;
      dv0_in[1].q = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx9_ff <= ctx9_in;
         dv0_ff <= dv0_in;
         ctxd_ff[0] <= ctx9_ff;
         for (int k = 1; k < tbik_pkg::DIV_STEPS; k++) ctxd_ff[k] <= ctxd_ff[k-1];
      end
   end

   for (genvar k = 0; k < tbik_pkg::DIV_STEPS; k++) begin : g_div
      tbik_pkg::div_type prev [2];
      logic [DW:0] r2 [2];

      if (k == 0) begin : g_first
         assign prev = dv0_ff;
      end else begin : g_next
         assign prev = dv_ff[k-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         assign r2[l] = {prev[l].r, 1'b0};

         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[k][l].den <= prev[l].den;
               if (r2[l] >= {1'b0, prev[l].den}) begin
                  dv_ff[k][l].r <= DW'(r2[l] - {1'b0, prev[l].den});
                  dv_ff[k][l].q <= {prev[l].q[tbik_pkg::DIV_STEPS-2:0], 1'b1};
               end else begin
                  dv_ff[k][l].r <= r2[l][DW-1:0];
                  dv_ff[k][l].q <= {prev[l].q[tbik_pkg::DIV_STEPS-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_comb begin
      ctx10_in = ctxd_ff[tbik_pkg::DIV_STEPS-1];
      ctx10_in.q0 = ctx10_in.eq0 ? (tbik_pkg::QUO_W'(1) << tbik_pkg::DIV_STEPS)
                                 : {1'b0, dv_ff[tbik_pkg::DIV_STEPS-1][0].q};
      ctx10_in.q1 = ctx10_in.eq1 ? (tbik_pkg::QUO_W'(1) << tbik_pkg::DIV_STEPS)
                                 : {1'b0, dv_ff[tbik_pkg::DIV_STEPS-1][1].q};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx10_ff <= ctx10_in;
         ctx11_ff <= ctx10_ff;
         qq_ff[0] <= ctx10_ff.q0 * ctx10_ff.q0;
         qq_ff[1] <= ctx10_ff.q1 * ctx10_ff.q1;
         ctx12_ff <= ctx11_ff;
         rad_ff[0] <= (tbik_pkg::SQB_IN_W'(1) << (2 * tbik_pkg::DIV_STEPS)) - qq_ff[0];
         rad_ff[1] <= (tbik_pkg::SQB_IN_W'(1) << (2 * tbik_pkg::DIV_STEPS)) - qq_ff[1];
         ctxs_ff[0] <= ctx12_ff;
         for (int k = 1; k < tbik_pkg::SQB_N; k++) ctxs_ff[k] <= ctxs_ff[k-1];
         ctxc_ff[0] <= ctxs_ff[tbik_pkg::SQB_N-1];
         for (int k = 1; k < LC; k++) ctxc_ff[k] <= ctxc_ff[k-1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_sin
      tbik_sqrt #(.IN_W(tbik_pkg::SQB_IN_W)) u_sin_sqrt (
         .clock    (clock),
         .en       (en),
         .radicand (rad_ff[l]),
         .root     (sin_root[l])
      );
   end

   always_comb begin
      tbik_pkg::ctx_type cb;
      cb = ctxs_ff[tbik_pkg::SQB_N-1];
      cx[0] = $signed({{(tbik_pkg::CRD_W-tbik_pkg::DIFF_W){cb.dx[32]}}, cb.dx});
      cy[0] = $signed({{(tbik_pkg::CRD_W-tbik_pkg::DIFF_W){cb.dy[32]}}, cb.dy});
      cx[1] = $signed({5'b0, cb.q0});
      if (cb.neg0) cx[1] = -cx[1];
      cx[2] = $signed({5'b0, cb.q1});
      if (cb.neg1) cx[2] = -cx[2];
      cy[1] = $signed({5'b0, sin_root[0]});
      cy[2] = $signed({5'b0, sin_root[1]});
   end

   for (genvar u = 0; u < 3; u++) begin : g_cordic
      tbik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
         .clock (clock),
         .en    (en),
         .vec_x (cx[u]),
         .vec_y (cy[u]),
         .angle (ang[u])
      );
   end

   always_comb begin
      ctxf = ctxc_ff[LC-1];
      a0f = flip_ff ? AW'(-ang[1]) : ang[1];
      a1f = flip_ff ? AW'(-ang[2]) : ang[2];
      upd_in = 1'b1;
      oor_in = 1'b0;
      glob_in = 1'b0;
      rot1_in = ang[0] - a0f - rest_one_ff;
      rot2_in = 16'h8000 - a1f - rest_two_ff + rest_one_ff;
      if (ctxf.oor) begin
         oor_in = 1'b1;
         glob_in = 1'b1;
         rot1_in = ang[0] - rest_one_ff;
         rot2_in = ang[0] - rest_two_ff;
      end else if (ctxf.bad) begin
         upd_in = 1'b0;
         rot1_in = '0;
         rot2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         upd_ff <= upd_in;
         oor_ff <= oor_in;
         rot1_ff <= rot1_in;
         rot2_ff <= rot2_in;
         glob_ff <= glob_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_update_valid = upd_ff;
   assign rsp_out_of_reach = oor_ff;
   assign rsp_rotation_one = $signed(rot1_ff);
   assign rsp_rotation_two = $signed(rot2_ff);
   assign rsp_rotation_two_global = glob_ff;

endmodule

// ===== sv/tbik_sqrt.sv =====
module tbik_sqrt #(
   parameter int IN_W = 66
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);

   localparam int N = IN_W / 2;
   localparam int RW = N + 3;

   logic [IN_W-1:0] x_ff    [N];
   logic [RW-1:0]   rem_ff  [N];
   logic [N-1:0]    root_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [IN_W-1:0] px;
      logic [RW-1:0]   prem;
      logic [N-1:0]    proot;
      logic [RW-1:0]   cur;
      logic [RW-1:0]   trial;

      if (j == 0) begin : g_first
         assign px = radicand;
         assign prem = '0;
         assign proot = '0;
      end else begin : g_next
         assign px = x_ff[j-1];
         assign prem = rem_ff[j-1];
         assign proot = root_ff[j-1];
      end

      assign cur = {prem[RW-3:0], px[IN_W-1-2*j -: 2]};
      assign trial = {1'b0, proot, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j] <= px;
            if (cur >= trial) begin
               rem_ff[j] <= cur - trial;
               root_ff[j] <= {proot[N-2:0], 1'b1};
            end else begin
               rem_ff[j] <= cur;
               root_ff[j] <= {proot[N-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

// ===== sv/tbik_cordic.sv =====
module tbik_cordic #(
   parameter int STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [tbik_pkg::CRD_W-1:0]     vec_x,
   input  logic signed [tbik_pkg::CRD_W-1:0]     vec_y,
   output logic        [tbik_pkg::ANG_W-1:0]     angle
);

   localparam int W = tbik_pkg::CRD_W;

   logic signed [W-1:0] x_ff    [STEPS+1];
   logic signed [W-1:0] y_ff    [STEPS+1];
   logic [31:0]         z_ff    [STEPS+1];
   logic                zero_ff [STEPS+1];
   logic [tbik_pkg::ANG_W-1:0] angle_ff;
   logic [31:0]         zround;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            if (vec_y >= 0) begin
               x_ff[0] <= vec_y;
               y_ff[0] <= -vec_x;
               z_ff[0] <= 32'h4000_0000;
            end else begin
               x_ff[0] <= -vec_y;
               y_ff[0] <= vec_x;
               z_ff[0] <= 32'hC000_0000;
            end
         end else begin
            x_ff[0] <= vec_x;
            y_ff[0] <= vec_y;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k+1] <= zero_ff[k];
            if (y_ff[k] > 0) begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + tbik_pkg::ATAN_TAB[k];
            end else begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - tbik_pkg::ATAN_TAB[k];
            end
         end
      end
   end

   assign zround = z_ff[STEPS] + 32'h0000_8000;

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= zero_ff[STEPS] ? '0 : zround[31:16];
      end
   end

   assign angle = angle_ff;

endmodule

// ===== sv/tbik_checker.sv =====
module tbik_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_update_valid,
   input logic        rsp_out_of_reach,
   input logic [15:0] rsp_rotation_one,
   input logic [15:0] rsp_rotation_two,
   input logic        rsp_rotation_two_global
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotation_one)
         && $stable(rsp_rotation_two) && $stable(rsp_update_valid))
      else $error("Result beat changed while stalled.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Request side stalled with an empty result register.");

   a_reach_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_of_reach != rsp_rotation_two_global) |-> 1'b0)
      else $error("Out-of-reach and global flags disagree.");

   a_reach_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_reach |-> rsp_update_valid)
      else $error("Out-of-reach result without an update.");

   a_no_update_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_update_valid |-> rsp_rotation_one == 16'h0000
         && rsp_rotation_two == 16'h0000)
      else $error("Rejected result carries nonzero rotations.");

endmodule

bind two_bone_ik_solver_core tbik_checker u_tbik_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_ready               (req_ready),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_update_valid        (rsp_update_valid),
   .rsp_out_of_reach        (rsp_out_of_reach),
   .rsp_rotation_one        (rsp_rotation_one),
   .rsp_rotation_two        (rsp_rotation_two),
   .rsp_rotation_two_global (rsp_rotation_two_global)
);

// ===== test/tb_top.sv =====
module tb_top;

   typedef struct {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] joint_x;
      logic signed [31:0] joint_y;
      logic [31:0]        length_one;
      logic [15:0]        scale_one_x;
      logic [15:0]        scale_one_y;
      logic [31:0]        length_two;
      logic [15:0]        scale_two_x;
      logic [15:0]        scale_two_y;
   } chain_type;

   typedef struct {
      logic        update_valid;
      logic        out_of_reach;
      logic [15:0] rotation_one;
      logic [15:0] rotation_two;
      logic        rotation_two_global;
   } pose_type;

   typedef struct {
      chain_type chain;
      bit        typed;
      pose_type  pose;
   } row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 160;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_target_x;
   logic signed [31:0] req_target_y;
   logic signed [31:0] req_joint_x;
   logic signed [31:0] req_joint_y;
   logic [31:0]        req_length_one;
   logic [15:0]        req_scale_one_x;
   logic [15:0]        req_scale_one_y;
   logic [31:0]        req_length_two;
   logic [15:0]        req_scale_two_x;
   logic [15:0]        req_scale_two_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_update_valid;
   logic               rsp_out_of_reach;
   logic signed [15:0] rsp_rotation_one;
   logic signed [15:0] rsp_rotation_two;
   logic               rsp_rotation_two_global;
   logic               csr_we;
   logic [tbik_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]        csr_wdata;

   logic [31:0] min_distance;
   logic [31:0] max_distance;
   logic        flip_bend;
   logic [15:0] rest_angle_one;
   logic [15:0] rest_angle_two;

   pose_type pose_q[$];
   bit       row_typed;
   pose_type row_pose;
   bit       failed;
   bit       gaps_on;
   bit       stalls_on;
   int       idle_cycles;
   int       n_beats;
   int       n_reach;
   int       n_invalid;

   two_bone_ik_solver_core i_dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [32:0] floor_root(logic [65:0] v);
      logic [69:0] rem;
      logic [69:0] trial;
      logic [33:0] root;
      rem = '0;
      root = '0;
      for (int k = 32; k >= 0; k--) begin
         rem = (rem << 2) | 70'(v[2*k +: 2]);
         trial = 70'({root, 2'b01});
         if (rem >= trial) begin
            rem = rem - trial;
            root = {root[32:0], 1'b1};
         end else begin
            root = {root[32:0], 1'b0};
         end
      end
      return root[32:0];
   endfunction

   function automatic logic [15:0] vector_angle(longint x, longint y);
      logic [31:0] z;
      longint      t;
      longint      xs;
      longint      ys;
      z = '0;
      if (x == 0 && y == 0) return 16'h0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 32'h4000_0000;
         end else begin
            x = -y;
            y = t;
            z = 32'hC000_0000;
         end
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + tbik_pkg::ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - tbik_pkg::ATAN_TAB[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   function automatic bit cosine_angle(longint num, longint den, output logic [15:0] ang);
      logic [63:0] a;
      logic [63:0] d;
      logic [63:0] q;
      logic [63:0] r;
      longint      s;
      longint      c;
      a = (num < 0) ? -num : num;
      d = den;
      q = '0;
      ang = '0;
      if (a > d) return 1'b0;
      if (a == d) begin
         q = 64'd1 << 30;
      end else begin
         r = a;
         for (int i = 0; i < 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
               r = r - d;
               q = q | 64'd1;
            end
         end
      end
      s = longint'(floor_root({2'b00, (64'd1 << 60) - q * q}));
      c = (num < 0) ? -longint'(q) : longint'(q);
      ang = vector_angle(c, s);
      return 1'b1;
   endfunction

   function automatic pose_type solve_chain(chain_type c);
      pose_type    p;
      longint      dx;
      longint      dy;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] d;
      logic [63:0] l1;
      logic [63:0] l2;
      logic [63:0] m;
      logic [15:0] s1;
      logic [15:0] s2;
      logic [15:0] heading;
      logic [15:0] a0;
      logic [15:0] a1;
      longint      sd;
      longint      n1;
      longint      n2;
      p = '{default: '0};
      dx = longint'(c.target_x) - longint'(c.joint_x);
      dy = longint'(c.target_y) - longint'(c.joint_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      d = 64'(floor_root(66'(ax * ax) + 66'(ay * ay)));
      s1 = (c.scale_one_x < c.scale_one_y) ? c.scale_one_x : c.scale_one_y;
      s2 = (c.scale_two_x < c.scale_two_y) ? c.scale_two_x : c.scale_two_y;
      l1 = (64'(c.length_one) * 64'(s1)) >> 8;
      l2 = (64'(c.length_two) * 64'(s2)) >> 8;
      heading = vector_angle(dx, dy);
      if (d < 64'(min_distance)) d = 64'(min_distance);
      if (max_distance != 0 && d > 64'(max_distance)) d = 64'(max_distance);
      if (l1 + l2 < d) begin
         p.update_valid = 1'b1;
         p.out_of_reach = 1'b1;
         p.rotation_one = heading - rest_angle_one;
         p.rotation_two = heading - rest_angle_two;
         p.rotation_two_global = 1'b1;
         return p;
      end
      m = d;
      if (l1 > m) m = l1;
      if (l2 > m) m = l2;
      while (m >= (64'd1 << 30)) begin
         m = m >> 1;
         d = d >> 1;
         l1 = l1 >> 1;
         l2 = l2 >> 1;
      end
      sd = d;
      n1 = l1;
      n2 = l2;
      if (sd == 0 || n1 == 0 || n2 == 0) return p;
      if (!cosine_angle(sd * sd + n1 * n1 - n2 * n2, 2 * sd * n1, a0)) return p;
      if (!cosine_angle(n2 * n2 + n1 * n1 - sd * sd, 2 * n2 * n1, a1)) return p;
      if (flip_bend) begin
         a0 = -a0;
         a1 = -a1;
      end
      p.update_valid = 1'b1;
      p.rotation_one = heading - a0 - rest_angle_one;
      p.rotation_two = 16'h8000 - a1 - rest_angle_two + rest_angle_one;
      return p;
   endfunction

   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         min_distance <= '0;
         max_distance <= '0;
         flip_bend <= 1'b0;
         rest_angle_one <= '0;
         rest_angle_two <= '0;
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (row_typed) begin
               pose_q.push_back(row_pose);
            end else begin
               pose_q.push_back(solve_chain('{req_target_x, req_target_y, req_joint_x,
                  req_joint_y, req_length_one, req_scale_one_x, req_scale_one_y,
                  req_length_two, req_scale_two_x, req_scale_two_y}));
            end
         end
         if (rsp_valid && rsp_ready) begin
            n_beats++;
            if (pose_q.size() == 0) begin
               $error("result beat with no expectation waiting");
               failed = 1'b1;
            end else begin
               want = pose_q.pop_front();
               if (want.out_of_reach) n_reach++;
               if (!want.update_valid) n_invalid++;
               if (rsp_update_valid !== want.update_valid) begin
                  $error("update_valid: expected %0d, actual %0d", want.update_valid,
                     rsp_update_valid);
                  failed = 1'b1;
               end
               if (rsp_out_of_reach !== want.out_of_reach) begin
                  $error("out_of_reach: expected %0d, actual %0d", want.out_of_reach,
                     rsp_out_of_reach);
                  failed = 1'b1;
               end
               if (rsp_rotation_one !== want.rotation_one) begin
                  $error("rotation_one: expected %h, actual %h", want.rotation_one,
                     rsp_rotation_one);
                  failed = 1'b1;
               end
               if (rsp_rotation_two !== want.rotation_two) begin
                  $error("rotation_two: expected %h, actual %h", want.rotation_two,
                     rsp_rotation_two);
                  failed = 1'b1;
               end
               if (rsp_rotation_two_global !== want.rotation_two_global) begin
                  $error("rotation_two_global: expected %0d, actual %0d",
                     want.rotation_two_global, rsp_rotation_two_global);
                  failed = 1'b1;
               end
            end
         end
         if (csr_we) begin
            case (tbik_pkg::csr_index_type'(csr_index))
               tbik_pkg::CSR_MIN_DISTANCE: min_distance <= csr_wdata;
               tbik_pkg::CSR_MAX_DISTANCE: max_distance <= csr_wdata;
               tbik_pkg::CSR_FLIP_BEND: flip_bend <= csr_wdata[0];
               tbik_pkg::CSR_REST_ANGLE_ONE: rest_angle_one <= csr_wdata[15:0];
               tbik_pkg::CSR_REST_ANGLE_TWO: rest_angle_two <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (pose_q.size() == 0 && !req_valid)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      forever begin
         stall = stalls_on ? $urandom_range(0, 17) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_chain(chain_type c, bit typed, pose_type p);
      int gap;
      gap = gaps_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      row_typed <= typed;
      row_pose <= p;
      req_valid <= 1'b1;
      req_target_x <= c.target_x;
      req_target_y <= c.target_y;
      req_joint_x <= c.joint_x;
      req_joint_y <= c.joint_y;
      req_length_one <= c.length_one;
      req_scale_one_x <= c.scale_one_x;
      req_scale_one_y <= c.scale_one_y;
      req_length_two <= c.length_two;
      req_scale_two_x <= c.scale_two_x;
      req_scale_two_y <= c.scale_two_y;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic write_csr(tbik_pkg::csr_index_type idx, logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pose_q.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] span_value();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 3));
         2, 3: return 16'($urandom_range(16'h0080, 16'h0200));
         default: return 16'h0100;
      endcase
   endfunction

   function automatic chain_type random_chain();
      chain_type c;
      int        e;
      logic [31:0] mask;
      if ($urandom_range(0, 9) == 0) begin
         c = '{$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
            16'($urandom), $urandom, 16'($urandom), 16'($urandom)};
         return c;
      end
      e = $urandom_range(2, 29);
      mask = (32'd1 << e) - 1;
      c.joint_x = $signed($urandom) >>> $urandom_range(1, 31);
      c.joint_y = $signed($urandom) >>> $urandom_range(1, 31);
      c.target_x = c.joint_x + ($signed($urandom & (mask << 1) | 32'(e)) >>> 0) *
         ($urandom_range(0, 1) ? 1 : -1);
      c.target_y = c.joint_y + $signed($urandom & (mask << 1)) * ($urandom_range(0, 1) ? 1 : -1);
      c.length_one = $urandom & mask;
      c.length_two = $urandom & mask;
      c.scale_one_x = pick_scale();
      c.scale_one_y = pick_scale();
      c.scale_two_x = pick_scale();
      c.scale_two_y = pick_scale();
      return c;
   endfunction

   initial begin
      row_type  rows[$];
      pose_type none;
      pose_type ahead;
      none = '{1'b0, 1'b0, 16'h0, 16'h0, 1'b0};
      ahead = '{1'b1, 1'b1, 16'h0, 16'h0, 1'b1};
      failed = 1'b0;
      n_beats = 0;
      n_reach = 0;
      n_invalid = 0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      row_typed <= 1'b0;
      row_pose <= none;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_target_x <= '0;
      req_target_y <= '0;
      req_joint_x <= '0;
      req_joint_y <= '0;
      req_length_one <= '0;
      req_scale_one_x <= '0;
      req_scale_one_y <= '0;
      req_length_two <= '0;
      req_scale_two_x <= '0;
      req_scale_two_y <= '0;
      csr_we <= 1'b0;
      csr_index <= tbik_pkg::CSR_MIN_DISTANCE;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Target on the joint with and without bones, a bare reach and a cosine beyond one come first.
      rows = '{
         '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, none},
         '{'{32'h10000, 0, 0, 0, 0, 16'h100, 16'h100, 0, 16'h100, 16'h100}, 1, ahead},
         '{'{5, -7, 5, -7, 32'h10000, 16'h100, 16'h100, 32'h10000, 16'h100, 16'h100},
            1, none},
         '{'{32'h10000, 0, 0, 0, 32'h10000, 16'h100, 16'h100, 32'hA0000, 16'h100,
            16'h100}, 1, none},
         '{'{32'h30000, 32'h40000, 0, 0, 32'h30000, 16'h100, 16'h100, 32'h30000, 16'h100,
            16'h100}, 0, none},
         '{'{-32'sh30000, 32'h40000, 0, 0, 32'h40000, 16'h100, 16'h100, 32'h20000, 16'h100,
            16'h100}, 0, none},
         '{'{-32'sh30000, -32'sh40000, 0, 0, 32'h20000, 16'h100, 16'h100, 32'h30000,
            16'h100, 16'h100}, 0, none},
         '{'{32'h30000, -32'sh40000, 0, 0, 32'h28000, 16'h100, 16'h100, 32'h28000,
            16'h100, 16'h100}, 0, none},
         '{'{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff,
            16'hffff, 16'hffff, 32'hffffffff, 16'hffff, 16'hffff}, 0, none},
         '{'{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            16'hffff, 16'hffff, 32'h1, 16'hffff, 16'hffff}, 0, none},
         '{'{32'h7fffffff, 0, 32'h80000000, 0, 32'hffffffff, 16'h0, 16'hffff, 32'hffffffff,
            16'hffff, 16'hffff}, 0, none},
         '{'{-32'sh50000, 0, 0, 0, 32'h10000, 16'h100, 16'h100, 32'h40000, 16'h100,
            16'h100}, 0, none},
         '{'{0, 32'h50000, 0, 0, 32'h30000, 16'h200, 16'h100, 32'h10000, 16'h100,
            16'h300}, 0, none},
         '{'{0, -32'sh1, 0, 0, 32'h1, 16'h1, 16'h1, 32'h1, 16'h1, 16'h1}, 0, none},
         '{'{32'h12345, 32'h6789, -32'sh4321, 32'h1111, 32'h20000, 16'h180, 16'h100,
            32'h18000, 16'h100, 16'h0c0}, 0, none}
      };
      foreach (rows[i]) send_chain(rows[i].chain, rows[i].typed, rows[i].pose);
      row_typed <= 1'b0;

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               write_csr(tbik_pkg::CSR_MIN_DISTANCE, 32'h30000);
               write_csr(tbik_pkg::CSR_MAX_DISTANCE, 32'h20000);
               write_csr(tbik_pkg::CSR_FLIP_BEND, 32'd1);
               write_csr(tbik_pkg::CSR_REST_ANGLE_ONE, 32'hffff8000);
               write_csr(tbik_pkg::CSR_REST_ANGLE_TWO, 32'h00007fff);
            end
            1: begin
               write_csr(tbik_pkg::CSR_MIN_DISTANCE, 32'hffffffff);
               write_csr(tbik_pkg::CSR_MAX_DISTANCE, 32'h0);
               write_csr(tbik_pkg::CSR_FLIP_BEND, 32'd0);
               write_csr(tbik_pkg::CSR_REST_ANGLE_ONE, 32'h00007fff);
               write_csr(tbik_pkg::CSR_REST_ANGLE_TWO, 32'hffff8000);
            end
            2: begin
               write_csr(tbik_pkg::CSR_MIN_DISTANCE, 32'h0);
               write_csr(tbik_pkg::CSR_MAX_DISTANCE, 32'hffffffff);
            end
            3: begin
               write_csr(tbik_pkg::CSR_MAX_DISTANCE, 32'h1);
               write_csr(tbik_pkg::CSR_FLIP_BEND, 32'd1);
            end
            default: begin
               write_csr(tbik_pkg::CSR_MIN_DISTANCE, $urandom_range(0, 1) ? span_value() : 0);
               write_csr(tbik_pkg::CSR_MAX_DISTANCE, $urandom_range(0, 1) ? span_value() : 0);
               write_csr(tbik_pkg::CSR_FLIP_BEND, $urandom);
               write_csr(tbik_pkg::CSR_REST_ANGLE_ONE, $urandom);
               write_csr(tbik_pkg::CSR_REST_ANGLE_TWO, $urandom);
            end
         endcase
         gaps_on = (phase % 3) != 1;
         stalls_on = (phase % 4) != 2;
         repeat (215) send_chain(random_chain(), 1'b0, none);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pose_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d result beats over ten register settings.", n_beats);
      $display("Out of reach: %0d, rejected solutions: %0d.", n_reach, n_invalid);
      if (!failed && pose_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
